// ===== rtl/dla_pkg.sv =====
package dla_pkg;

    localparam int STORE_DEPTH_DEFAULT = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int DIST_W     = 16;
    localparam int DELAY_W    = 12;
    localparam int COEFF_W    = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = SAMPLE_W + DIST_W;
    localparam int M_DATA_W   = SAMPLE_W;

    localparam int RED_CNT_W  = $clog2(DELAY_W);
    localparam int DIV_NUM_W  = SAMPLE_W + 8;
    localparam int DIV_DEN_W  = DIST_W + 2;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int ACC_W      = 2 * (SAMPLE_W + 1);
    localparam int PC_W       = 4;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY = 2'd0,
        REG_COEFF = 2'd1,
        REG_PATH  = 2'd2,
        REG_MODE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAW   = 2'd0,
        MODE_AIR   = 2'd1,
        MODE_ATTEN = 2'd2
    } out_mode_t;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_ACCEPT   = 4'd1,
        OP_RED_INIT = 4'd2,
        OP_RED_STEP = 4'd3,
        OP_RD_SET   = 4'd4,
        OP_READ     = 4'd5,
        OP_LOAD_S   = 4'd6,
        OP_FILT_MUL = 4'd7,
        OP_FILT_RND = 4'd8,
        OP_DIV_INIT = 4'd9,
        OP_DIV_STEP = 4'd10,
        OP_DIV_FIN  = 4'd11,
        OP_OUT_LOAD = 4'd12
    } op_t;

    typedef enum logic [3:0] {
        COND_NEVER     = 4'd0,
        COND_ALWAYS    = 4'd1,
        COND_NO_INPUT  = 4'd2,
        COND_NO_RELOAD = 4'd3,
        COND_RED_BUSY  = 4'd4,
        COND_MODE_RAW  = 4'd5,
        COND_MODE_AIR  = 4'd6,
        COND_DIV_BUSY  = 4'd7,
        COND_OUT_BUSY  = 4'd8
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic reload_pend;
        logic red_busy;
        logic mode_raw;
        logic mode_air;
        logic div_busy;
        logic out_busy;
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_ACCEPT   = 4'd0;
    localparam logic [PC_W-1:0] PC_RED_STEP = 4'd2;
    localparam logic [PC_W-1:0] PC_READ     = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd9;
    localparam logic [PC_W-1:0] PC_OUT      = 4'd11;

    function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_ACCEPT,   cond: COND_NO_INPUT,  target: PC_ACCEPT};
            4'd1:    w = '{op: OP_RED_INIT, cond: COND_NO_RELOAD, target: PC_READ};
            4'd2:    w = '{op: OP_RED_STEP, cond: COND_RED_BUSY,  target: PC_RED_STEP};
            4'd3:    w = '{op: OP_RD_SET,   cond: COND_NEVER,     target: PC_ACCEPT};
            4'd4:    w = '{op: OP_READ,     cond: COND_NEVER,     target: PC_ACCEPT};
            4'd5:    w = '{op: OP_LOAD_S,   cond: COND_MODE_RAW,  target: PC_OUT};
            4'd6:    w = '{op: OP_FILT_MUL, cond: COND_NEVER,     target: PC_ACCEPT};
            4'd7:    w = '{op: OP_FILT_RND, cond: COND_MODE_AIR,  target: PC_OUT};
            4'd8:    w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: PC_ACCEPT};
            4'd9:    w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY,  target: PC_DIV_STEP};
            4'd10:   w = '{op: OP_DIV_FIN,  cond: COND_NEVER,     target: PC_ACCEPT};
            4'd11:   w = '{op: OP_OUT_LOAD, cond: COND_OUT_BUSY,  target: PC_OUT};
            default: w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/dla_sequencer.sv =====
module dla_sequencer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dla_pkg::dp_status_t     status,
    output dla_pkg::op_t            op
);
    import dla_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take_jump;

    assign uw = ucode_word(pc_reg);
    assign op = uw.op;

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:     take_jump = 1'b0;
            COND_ALWAYS:    take_jump = 1'b1;
            COND_NO_INPUT:  take_jump = !status.in_valid;
            COND_NO_RELOAD: take_jump = !status.reload_pend;
            COND_RED_BUSY:  take_jump = status.red_busy;
            COND_MODE_RAW:  take_jump = status.mode_raw;
            COND_MODE_AIR:  take_jump = status.mode_air;
            COND_DIV_BUSY:  take_jump = status.div_busy;
            COND_OUT_BUSY:  take_jump = status.out_busy;
            default:        take_jump = 1'b1;
        endcase
        pc_next = take_jump ? uw.target : PC_W'(pc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/dla_datapath.sv =====
module dla_datapath #(
    parameter int STORE_DEPTH = dla_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dla_pkg::op_t                   op,
    output dla_pkg::dp_status_t            status,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dla_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dla_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [dla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dla_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dla_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int RED_W = CNT_W + DELAY_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_DEPTH);

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32767);
        lo = -ACC_W'(32768);
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return SAMPLE_W'(v);
    endfunction

    logic [DELAY_W-1:0]          delay_reg;
    logic [COEFF_W-1:0]          coeff_reg;
    logic [DIST_W-1:0]           path_reg;
    logic [MODE_W-1:0]           mode_reg;
    logic                        pend_reg;

    logic [IDX_W-1:0]            wr_idx_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic [CNT_W-1:0]            fill_reg;

    logic signed [SAMPLE_W-1:0]  store_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0]  mem_q_reg;
    logic                        rd_ok_reg;

    logic [DIST_W-1:0]           extra_reg;

    logic [DELAY_W-1:0]          red_rem_reg;
    logic [RED_CNT_W-1:0]        red_k_reg;

    logic signed [SAMPLE_W-1:0]  s_reg;
    logic signed [SAMPLE_W-1:0]  filt_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic [DIV_NUM_W-1:0]        dq_reg;
    logic [DIV_DEN_W-1:0]        drem_reg;
    logic [DIV_DEN_W-1:0]        dden_reg;
    logic [DIV_CNT_W-1:0]        dcnt_reg;
    logic                        dneg_reg;

    logic                        m_valid_reg;
    logic [M_DATA_W-1:0]         m_data_reg;

    logic                        in_fire;
    logic                        out_free;
    logic [RED_W-1:0]            red_shift;
    logic [RED_W-1:0]            red_ext;
    logic [CNT_W-1:0]            wr_c;
    logic [CNT_W-1:0]            rem_c;
    logic [CNT_W-1:0]            rd_calc;
    logic [IDX_W-1:0]            wr_inc;
    logic [IDX_W-1:0]            rd_inc;
    logic signed [SAMPLE_W:0]    diff;
    logic signed [ACC_W-1:0]     prod;
    logic signed [ACC_W-1:0]     xs;
    logic signed [ACC_W-1:0]     rsum;
    logic signed [SAMPLE_W-1:0]  y_filt;
    logic [SAMPLE_W-1:0]         mag;
    logic [DIV_DEN_W+1:0]        trial;
    logic signed [ACC_W-1:0]     q_signed;

    assign s_tready = (op == OP_ACCEPT) && aresetn;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign status.in_valid    = s_tvalid;
    assign status.reload_pend = pend_reg;
    assign status.red_busy    = (red_k_reg != '0);
    assign status.mode_raw    = !(mode_reg == MODE_AIR || mode_reg == MODE_ATTEN);
    assign status.mode_air    = (mode_reg == MODE_AIR);
    assign status.div_busy    = (dcnt_reg != DIV_CNT_W'(1));
    assign status.out_busy    = m_valid_reg && !m_tready;

    always_comb begin
        red_shift = RED_W'(DEPTH_C) << red_k_reg;
        red_ext   = RED_W'(red_rem_reg);
        wr_c      = {1'b0, wr_idx_reg};
        rem_c     = CNT_W'(red_rem_reg);
        if (wr_c >= rem_c) begin
            rd_calc = wr_c - rem_c;
        end else begin
            rd_calc = wr_c + DEPTH_C - rem_c;
        end
        wr_inc = (wr_idx_reg == IDX_LAST) ? '0 : IDX_W'(wr_idx_reg + 1'b1);
        rd_inc = (rd_idx_reg == IDX_LAST) ? '0 : IDX_W'(rd_idx_reg + 1'b1);

        diff   = (SAMPLE_W + 1)'(filt_reg) - (SAMPLE_W + 1)'(s_reg);
        prod   = $signed({1'b0, coeff_reg}) * diff;
        xs     = ACC_W'($signed({s_reg, 16'h0000}));
        rsum   = acc_reg + ACC_W'(32768);
        y_filt = sat16(rsum >>> 16);

        mag    = s_reg[SAMPLE_W-1] ? SAMPLE_W'(-s_reg) : SAMPLE_W'(s_reg);
        trial  = {1'b0, drem_reg, dq_reg[DIV_NUM_W-1]} - {2'b00, dden_reg};
        q_signed = dneg_reg ? -ACC_W'(dq_reg[SAMPLE_W-1:0]) : ACC_W'(dq_reg[SAMPLE_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            store_mem[wr_idx_reg] <= s_tdata[SAMPLE_W-1:0];
        end
        if (op == OP_READ) begin
            mem_q_reg <= store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= '0;
            coeff_reg   <= '0;
            path_reg    <= '0;
            mode_reg    <= '0;
            pend_reg    <= 1'b0;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            filt_reg    <= '0;
            red_k_reg   <= '0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DELAY: begin
                        delay_reg <= cfg_wdata[DELAY_W-1:0];
                        pend_reg  <= 1'b1;
                    end
                    REG_COEFF: coeff_reg <= cfg_wdata[COEFF_W-1:0];
                    REG_PATH:  path_reg  <= cfg_wdata[DIST_W-1:0];
                    REG_MODE:  mode_reg  <= cfg_wdata[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_fire && fill_reg != DEPTH_C) begin
                fill_reg <= CNT_W'(fill_reg + 1'b1);
            end

            case (op)
                OP_RED_INIT: red_k_reg <= RED_CNT_W'(DELAY_W - 1);
                OP_RED_STEP: red_k_reg <= RED_CNT_W'(red_k_reg - 1'b1);
                OP_RD_SET: begin
                    rd_idx_reg <= rd_calc[IDX_W-1:0];
                    pend_reg   <= 1'b0;
                end
                OP_READ: begin
                    rd_idx_reg <= rd_inc;
                    wr_idx_reg <= wr_inc;
                end
                OP_FILT_RND: filt_reg <= y_filt;
                OP_DIV_INIT: dcnt_reg <= DIV_STEPS;
                OP_DIV_STEP: dcnt_reg <= DIV_CNT_W'(dcnt_reg - 1'b1);
                default: begin
                end
            endcase

            if (op == OP_OUT_LOAD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            extra_reg <= s_tdata[S_DATA_W-1:SAMPLE_W];
        end
        case (op)
            OP_RED_INIT: red_rem_reg <= delay_reg;
            OP_RED_STEP: begin
                if (red_ext >= red_shift) begin
                    red_rem_reg <= DELAY_W'(red_ext - red_shift);
                end
            end
            OP_READ:     rd_ok_reg <= ({1'b0, rd_idx_reg} < fill_reg);
            OP_LOAD_S:   s_reg <= rd_ok_reg ? mem_q_reg : '0;
            OP_FILT_MUL: acc_reg <= xs + prod;
            OP_FILT_RND: s_reg <= y_filt;
            OP_DIV_INIT: begin
                dq_reg   <= {mag, 8'h00};
                drem_reg <= '0;
                dden_reg <= DIV_DEN_W'(path_reg) + DIV_DEN_W'(extra_reg) + DIV_DEN_W'(256);
                dneg_reg <= s_reg[SAMPLE_W-1];
            end
            OP_DIV_STEP: begin
                if (!trial[DIV_DEN_W+1]) begin
                    drem_reg <= trial[DIV_DEN_W-1:0];
                    dq_reg   <= {dq_reg[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    drem_reg <= {drem_reg[DIV_DEN_W-2:0], dq_reg[DIV_NUM_W-1]};
                    dq_reg   <= {dq_reg[DIV_NUM_W-2:0], 1'b0};
                end
            end
            OP_DIV_FIN:  s_reg <= sat16(q_signed);
            default: begin
            end
        endcase
        if (op == OP_OUT_LOAD && out_free) begin
            m_data_reg <= s_reg;
        end
    end

endmodule

// ===== rtl/delay_line_air_absorption_unit.sv =====
// The microcode program takes each item through the accept, the store read, the lowpass
// (skipped in raw mode and with the unused mode code) and, in attenuation mode, the distance
// divide, and then offers the output transfer. The first item after a delay write also runs
// the read-position reduction. A new item is taken only after the last is loaded for output.
// Divides use the one-bit-per-cycle restoring divider; the sample store is read once per item.
// Reset is synchronous and active low; the store reads as zero until written.
module delay_line_air_absorption_unit #(
    parameter int STORE_DEPTH = dla_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dla_pkg::S_DATA_W-1:0]   s_tdata,   // in_sample [15:0], extra_distance [31:16]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dla_pkg::M_DATA_W-1:0]   m_tdata,   // out_sample [15:0]
    input  logic                           cfg_we,
    input  logic [dla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dla_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dla_pkg::*;

    op_t        op;
    dp_status_t status;

    dla_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    dla_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== rtl/dla_checker.sv =====
module dla_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dla_pkg::M_DATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input taken again before the item finished");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
        else $error("result offered too soon after an input transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

endmodule

bind delay_line_air_absorption_unit dla_checker u_chk (.*);

// ===== verif/testbench.sv =====
module testbench;
    import dla_pkg::*;

    localparam int LINE_DEPTH    = STORE_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int QUIET_TAIL    = 150;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum bit {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    reg_idx;
        logic [15:0] value;
        int          smp;
        logic [15:0] extra_val;
        bit          typed;
        int          want;
    } plan_row_t;

    plan_row_t directed_plan [$] = '{
        '{ROW_ITEM,  REG_DELAY, 16'd0,           32767, 16'd0,     1, 32767},
        '{ROW_ITEM,  REG_DELAY, 16'd0,          -32768, 16'd65535, 1, -32768},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               0, 16'd1,     1, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               1, 16'd0,     1, 1},
        '{ROW_WRITE, REG_MODE,  16'(MODE_AIR),       0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,              -1, 16'd0,     1, -1},
        '{ROW_ITEM,  REG_DELAY, 16'd0,           12345, 16'd77,    1, 12345},
        '{ROW_WRITE, REG_MODE,  16'(MODE_ATTEN),     0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,           32767, 16'd0,     1, 32767},
        '{ROW_ITEM,  REG_DELAY, 16'd0,          -32768, 16'd0,     1, -32768},
        '{ROW_WRITE, REG_PATH,  16'd65535,           0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,           32767, 16'd65535, 1, 63},
        '{ROW_ITEM,  REG_DELAY, 16'd0,          -32768, 16'd65535, 1, -63},
        '{ROW_WRITE, REG_COEFF, 16'd65535,           0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,           32767, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,          -32768, 16'd65535, 0, 0},
        '{ROW_WRITE, REG_MODE,  16'(MODE_AIR),       0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,           21000, 16'd0,     0, 0},
        '{ROW_WRITE, REG_MODE,  16'(MODE_RAW),       0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,             100, 16'd0,     1, 100},
        '{ROW_WRITE, REG_MODE,  16'(MODE_UNUSED),    0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,              -5, 16'd0,     1, -5},
        '{ROW_WRITE, REG_MODE,  16'(MODE_AIR),       0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               0, 16'd0,     0, 0},
        '{ROW_WRITE, REG_DELAY, 16'd4095,            0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               7, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,              -7, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               9, 16'd0,     0, 0},
        '{ROW_WRITE, REG_DELAY, 16'd1,               0, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               2, 16'd0,     0, 0},
        '{ROW_ITEM,  REG_DELAY, 16'd0,               3, 16'd0,     0, 0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_index = REG_DELAY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    logic [DELAY_W-1:0]         wr_ptr   = '0;
    logic [DELAY_W-1:0]         rd_ptr   = '0;
    logic signed [SAMPLE_W-1:0] lp_state = '0;
    logic [COEFF_W-1:0]         coeff_q  = '0;
    logic [DIST_W-1:0]          path_q   = '0;
    logic [MODE_W-1:0]          mode_q   = '0;

    logic signed [SAMPLE_W-1:0] pending_out [$];

    int fault_count = 0;
    int tx_pct      = 0;
    int rx_pct      = 0;
    int rx_stall    = 0;
    bit fresh_items = 0;

    delay_line_air_absorption_unit #(
        .STORE_DEPTH(LINE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [SAMPLE_W-1:0] saturate_sample(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] absorb_delayed_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [DIST_W-1:0]          extra
    );
        longint                     c;
        longint                     acc;
        longint                     d;
        longint                     mag;
        longint                     q;
        logic signed [SAMPLE_W-1:0] s;
        line_mem[wr_ptr] = smp;
        wr_ptr = wr_ptr + 1'b1;
        s = line_mem[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        if (mode_q == MODE_AIR || mode_q == MODE_ATTEN) begin
            c = longint'(coeff_q);
            acc = (65536 - c) * longint'(s) + c * longint'(lp_state);
            lp_state = saturate_sample((acc + 32768) >>> 16);
            s = lp_state;
            if (mode_q == MODE_ATTEN) begin
                d = longint'(path_q) + longint'(extra) + 256;
                mag = (s < 0) ? -longint'(s) : longint'(s);
                q = (mag * 256) / d;
                s = saturate_sample((s < 0) ? -q : q);
            end
        end
        return s;
    endfunction

    function automatic void apply_register(input cfg_reg_t idx, input logic [15:0] val);
        case (idx)
            REG_DELAY: rd_ptr = wr_ptr - val[DELAY_W-1:0];
            REG_COEFF: coeff_q = val[COEFF_W-1:0];
            REG_PATH:  path_q = val[DIST_W-1:0];
            REG_MODE:  mode_q = val[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int idle_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 5;
            3:       return 20;
            default: return 50;
        endcase
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", what);
        end
    endtask

    // Registers change only once the block has delivered everything and gone quiet.
    task automatic settle_block();
        if (fresh_items) begin
            s_tvalid <= 1'b0;
            while (pending_out.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            fresh_items = 0;
        end
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [15:0] val);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [DIST_W-1:0]          extra,
        input bit                         typed,
        input logic signed [SAMPLE_W-1:0] want
    );
        logic signed [SAMPLE_W-1:0] predicted;
        if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {extra, smp};
        do @(posedge aclk); while (!s_tready);
        predicted = absorb_delayed_sample(smp, extra);
        pending_out.push_back(typed ? want : predicted);
        fresh_items = 1;
    endtask

    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_fault($sformatf("unexpected out_sample transfer: %0d",
                                       $signed(m_tdata)));
            end else begin
                want = pending_out.pop_front();
                if (m_tdata !== want) begin
                    report_fault($sformatf("out_sample mismatch: expected %0d, got %0d",
                                           want, $signed(m_tdata)));
                end
            end
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
            rx_stall = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("testbench failed");
        $finish;
    end

    initial begin
        int                         sent;
        int                         burst;
        int                         pick;
        logic [15:0]                val;
        logic signed [SAMPLE_W-1:0] smp;
        logic [DIST_W-1:0]          extra;
        foreach (line_mem[i]) line_mem[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE) begin
                write_register(directed_plan[i].reg_idx, directed_plan[i].value);
            end else begin
                send_item(SAMPLE_W'(directed_plan[i].smp), directed_plan[i].extra_val,
                          directed_plan[i].typed, SAMPLE_W'(directed_plan[i].want));
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(1, 15);
            if (pick[0]) begin
                case ($urandom_range(0, 4))
                    0:       val = 16'd0;
                    1:       val = 16'd4095;
                    2:       val = 16'($urandom_range(0, 16));
                    3:       val = 16'($urandom_range(1, 3));
                    default: val = 16'($urandom_range(0, 4095));
                endcase
                write_register(REG_DELAY, val);
            end
            if (pick[1]) begin
                case ($urandom_range(0, 3))
                    0:       val = 16'd0;
                    1:       val = 16'hffff;
                    2:       val = 16'($urandom_range(60000, 65535));
                    default: val = 16'($urandom);
                endcase
                write_register(REG_COEFF, val);
            end
            if (pick[2]) begin
                case ($urandom_range(0, 3))
                    0:       val = 16'd0;
                    1:       val = 16'hffff;
                    2:       val = 16'($urandom_range(0, 1024));
                    default: val = 16'($urandom);
                endcase
                write_register(REG_PATH, val);
            end
            if (pick[3]) begin
                case ($urandom_range(0, 6))
                    0:       val = 16'(MODE_RAW);
                    1:       val = 16'(MODE_UNUSED);
                    2, 3:    val = 16'(MODE_AIR);
                    default: val = 16'(MODE_ATTEN);
                endcase
                write_register(REG_MODE, val);
            end

            if (RANDOM_ITEMS - sent <= QUIET_TAIL) begin
                tx_pct = 0;
                rx_pct = 0;
            end else begin
                tx_pct = idle_pct();
                rx_pct = idle_pct();
            end

            burst = $urandom_range(10, 60);
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0:       smp = 16'sh7fff;
                    1:       smp = 16'sh8000;
                    2, 3:    smp = 16'($urandom_range(0, 128)) - 16'd64;
                    default: smp = 16'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0:       extra = 16'd0;
                    1:       extra = 16'hffff;
                    2, 3, 4: extra = 16'($urandom_range(0, 512));
                    default: extra = 16'($urandom);
                endcase
                send_item(smp, extra, 1'b0, '0);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
